// File: rtl/ptd_pkg.sv
// Shared widths, command codes and queue entry types for the tick dispatcher.
package ptd_pkg;

  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned SLOT_W  = 8;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned FSLOT_W = 3;

  localparam int unsigned MAX_RESULTS = 8;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam int unsigned DEF_TASK_SLOTS    = 8;
  localparam int unsigned DEF_RELOAD_OFFSET = 1;

  // command codes on the func field
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_CREATE = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_START  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_STOP   = 3'd4;

  // classified operation; OP_BAD covers unknown codes and out-of-range slots
  typedef enum logic [2:0] {
    OP_TICK,
    OP_CREATE,
    OP_DELETE,
    OP_START,
    OP_STOP,
    OP_BAD
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [SLOT_W-1:0]   task_slot;
    logic [TIME_W-1:0]   period;
    logic [TIME_W-1:0]   first_delay;
    logic                start_paused;
  } cmd_t;

  typedef struct packed {
    logic               status;
    logic               fired;
    logic [FSLOT_W-1:0] fired_slot;
    logic               last;
  } res_t;

endpackage

// File: rtl/ptd_if.sv
// Valid/ready channel interfaces for commands and results.
interface ptd_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [ptd_pkg::FUNC_W-1:0]   func;
  logic [ptd_pkg::SLOT_W-1:0]   task_slot;
  logic [ptd_pkg::TIME_W-1:0]   period;
  logic [ptd_pkg::TIME_W-1:0]   first_delay;
  logic                         start_paused;

  modport source (output valid, func, task_slot, period, first_delay, start_paused,
                  input ready);
  modport sink (input valid, func, task_slot, period, first_delay, start_paused,
                output ready);
endinterface

interface ptd_res_if;
  logic                         valid;
  logic                         ready;
  logic                         status;
  logic                         fired;
  logic [ptd_pkg::FSLOT_W-1:0]  fired_slot;
  logic                         last;

  modport source (output valid, status, fired, fired_slot, last, input ready);
  modport sink (input valid, status, fired, fired_slot, last, output ready);
endinterface

// File: rtl/periodic_task_tick_dispatcher_top.sv
// Top level of the periodic task tick dispatcher.
//
// cmd_i carries one command per transaction: tick, create, delete, start
// or stop, with slot, period, first delay and start-paused fields. res_o
// returns results: one per command (status 1 on a bad code, an out-of-range
// slot or an empty slot), and on a tick one per reported firing slot in
// index order (at most eight), or a single empty result when nothing fires.
// The final result of every command carries last.
//
// Commands pass a classify register and a two-entry queue, so the front
// keeps taking transactions while the back is busy. A command result
// passes the classify register, the queue and the output register. A tick
// walks the countdown/period memories one slot per cycle, unless a held
// firing waits on a stalled res_o, through a single read port.
//
// Reset clears all slots to empty; countdown, period and pause state are
// written by create before they are ever used. When res_o stalls, the
// output register holds its result, the walk freezes in place and the
// queue fills, after which cmd_i.ready drops.
module periodic_task_tick_dispatcher_top #(
  parameter int unsigned TASK_SLOTS    = ptd_pkg::DEF_TASK_SLOTS,
  parameter int unsigned RELOAD_OFFSET = ptd_pkg::DEF_RELOAD_OFFSET
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ptd_cmd_if.sink   cmd_i,
  ptd_res_if.source res_o
);

  // classified commands from the front stage
  logic          fr_valid;
  logic          fr_ready;
  ptd_pkg::cmd_t fr_data;

  // queue head toward the back stage
  logic          q_valid;
  logic          q_ready;
  ptd_pkg::cmd_t q_data;

  ptd_front #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_i),
    .valid_o (fr_valid),
    .ready_i (fr_ready),
    .data_o  (fr_data)
  );

  ptd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_data),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_data)
  );

  ptd_back #(
    .TASK_SLOTS    (TASK_SLOTS),
    .RELOAD_OFFSET (RELOAD_OFFSET)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_ready_o (q_ready),
    .q_data_i  (q_data),
    .res_o     (res_o)
  );

endmodule

// File: rtl/ptd_front.sv
// Front stage: takes command transactions, range-checks and classifies them.
module ptd_front #(
  parameter int unsigned TASK_SLOTS = ptd_pkg::DEF_TASK_SLOTS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  ptd_cmd_if.sink         cmd_i,
  output logic            valid_o,
  input  logic            ready_i,
  output ptd_pkg::cmd_t   data_o
);

  logic          valid_q;
  ptd_pkg::cmd_t data_q;
  ptd_pkg::cmd_t data_d;
  logic          in_range;

  assign cmd_i.ready = !valid_q || ready_i;
  assign valid_o     = valid_q;
  assign data_o      = data_q;

  assign in_range = cmd_i.task_slot < ptd_pkg::SLOT_W'(TASK_SLOTS);

  always_comb begin
    data_d.task_slot    = cmd_i.task_slot;
    data_d.period       = cmd_i.period;
    data_d.first_delay  = cmd_i.first_delay;
    data_d.start_paused = cmd_i.start_paused;
    case (cmd_i.func)
      ptd_pkg::FUNC_TICK:   data_d.op = ptd_pkg::OP_TICK;
      ptd_pkg::FUNC_CREATE: data_d.op = in_range ? ptd_pkg::OP_CREATE : ptd_pkg::OP_BAD;
      ptd_pkg::FUNC_DELETE: data_d.op = in_range ? ptd_pkg::OP_DELETE : ptd_pkg::OP_BAD;
      ptd_pkg::FUNC_START:  data_d.op = in_range ? ptd_pkg::OP_START : ptd_pkg::OP_BAD;
      ptd_pkg::FUNC_STOP:   data_d.op = in_range ? ptd_pkg::OP_STOP : ptd_pkg::OP_BAD;
      default:              data_d.op = ptd_pkg::OP_BAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.ready) begin
      valid_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ready && cmd_i.valid) begin
      data_q <= data_d;
    end
  end

endmodule

// File: rtl/ptd_queue.sv
// Two-entry command queue between the front and back stages.
module ptd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  ptd_pkg::cmd_t   push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output ptd_pkg::cmd_t   pop_data_o
);

  ptd_pkg::cmd_t entry_q [2];
  logic          wr_ptr_q;
  logic          rd_ptr_q;
  logic [1:0]    cnt_q;
  logic          do_push;
  logic          do_pop;

  assign push_ready_o = cnt_q != 2'd2;
  assign pop_valid_o  = cnt_q != 2'd0;
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/ptd_back.sv
// Back stage: slot table, command execution and the per-tick slot walk.
module ptd_back #(
  parameter int unsigned TASK_SLOTS    = ptd_pkg::DEF_TASK_SLOTS,
  parameter int unsigned RELOAD_OFFSET = ptd_pkg::DEF_RELOAD_OFFSET
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  output logic            q_ready_o,
  input  ptd_pkg::cmd_t   q_data_i,
  ptd_res_if.source       res_o
);

  localparam int unsigned IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);
  localparam logic [ptd_pkg::TIME_W-1:0] OFFSET = ptd_pkg::TIME_W'(RELOAD_OFFSET);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIN
  } state_e;

  state_e                        state_q;
  logic [TASK_SLOTS-1:0]         occ_q;
  logic [TASK_SLOTS-1:0]         paused_q;
  logic [IDX_W-1:0]              idx_q;
  logic [ptd_pkg::CNT_W-1:0]     cnt_q;
  logic                          held_valid_q;
  logic [ptd_pkg::FSLOT_W-1:0]   held_slot_q;
  logic                          out_valid_q;
  ptd_pkg::res_t                 out_q;

  logic [ptd_pkg::TIME_W-1:0]    cd_mem  [TASK_SLOTS];
  logic [ptd_pkg::TIME_W-1:0]    per_mem [TASK_SLOTS];
  logic [ptd_pkg::TIME_W-1:0]    cd_rd_q;
  logic [ptd_pkg::TIME_W-1:0]    per_rd_q;

  logic                          can_push;
  logic [IDX_W-1:0]              cmd_idx;
  logic                          cmd_err;
  logic                          rd_en;
  logic [IDX_W-1:0]              rd_addr;
  logic                          cd_we;
  logic [IDX_W-1:0]              cd_wa;
  logic [ptd_pkg::TIME_W-1:0]    cd_wd;
  logic                          per_we;
  logic                          active;
  logic                          fire;
  logic                          report;
  logic                          step_go;
  logic [ptd_pkg::TIME_W-1:0]    reload;
  logic                          push;
  ptd_pkg::res_t                 push_res;

  assign can_push = !out_valid_q || res_o.ready;
  assign cmd_idx  = q_data_i.task_slot[IDX_W-1:0];

  assign res_o.valid      = out_valid_q;
  assign res_o.status     = out_q.status;
  assign res_o.fired      = out_q.fired;
  assign res_o.fired_slot = out_q.fired_slot;
  assign res_o.last       = out_q.last;

  assign active  = occ_q[idx_q] && !paused_q[idx_q];
  assign fire    = active && (cd_rd_q == '0);
  assign report  = fire && (cnt_q < ptd_pkg::CNT_W'(ptd_pkg::MAX_RESULTS));
  assign step_go = !(report && held_valid_q) || can_push;
  assign reload  = (per_rd_q >= OFFSET) ? per_rd_q - OFFSET : '0;

  always_comb begin
    case (q_data_i.op)
      ptd_pkg::OP_CREATE: cmd_err = 1'b0;
      ptd_pkg::OP_DELETE,
      ptd_pkg::OP_START,
      ptd_pkg::OP_STOP:   cmd_err = !occ_q[cmd_idx];
      default:            cmd_err = 1'b1;
    endcase
  end

  always_comb begin
    q_ready_o = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    cd_we     = 1'b0;
    cd_wa     = cmd_idx;
    cd_wd     = q_data_i.first_delay;
    per_we    = 1'b0;
    push      = 1'b0;
    push_res  = '0;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          if (q_data_i.op == ptd_pkg::OP_TICK) begin
            q_ready_o = 1'b1;
            rd_en     = 1'b1;
          end else if (can_push) begin
            q_ready_o       = 1'b1;
            push            = 1'b1;
            push_res.status = cmd_err;
            push_res.last   = 1'b1;
            if (q_data_i.op == ptd_pkg::OP_CREATE) begin
              cd_we  = 1'b1;
              per_we = 1'b1;
            end
          end
        end
      end
      ST_WALK: begin
        if (step_go) begin
          if (active) begin
            cd_we = 1'b1;
            cd_wa = idx_q;
            cd_wd = fire ? reload : cd_rd_q - 1'b1;
          end
          // an earlier firing goes out once we know it is not the last one
          if (report && held_valid_q) begin
            push                = 1'b1;
            push_res.fired      = 1'b1;
            push_res.fired_slot = held_slot_q;
          end
          if (idx_q != LAST_IDX) begin
            rd_en   = 1'b1;
            rd_addr = idx_q + 1'b1;
          end
        end
      end
      ST_FIN: begin
        if (can_push) begin
          push                = 1'b1;
          push_res.fired      = held_valid_q;
          push_res.fired_slot = held_valid_q ? held_slot_q : '0;
          push_res.last       = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      occ_q        <= '0;
      idx_q        <= '0;
      cnt_q        <= '0;
      held_valid_q <= 1'b0;
      held_slot_q  <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      if (push) begin
        out_valid_q <= 1'b1;
        out_q       <= push_res;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (q_ready_o) begin
            case (q_data_i.op)
              ptd_pkg::OP_TICK: begin
                state_q      <= ST_WALK;
                idx_q        <= '0;
                cnt_q        <= '0;
                held_valid_q <= 1'b0;
              end
              ptd_pkg::OP_CREATE: occ_q[cmd_idx] <= 1'b1;
              ptd_pkg::OP_DELETE: occ_q[cmd_idx] <= 1'b0;
              default: ;
            endcase
          end
        end
        ST_WALK: begin
          if (step_go) begin
            if (report) begin
              held_valid_q <= 1'b1;
              held_slot_q  <= ptd_pkg::FSLOT_W'(idx_q);
              cnt_q        <= cnt_q + 1'b1;
            end
            if (idx_q == LAST_IDX) begin
              state_q <= ST_FIN;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        ST_FIN: begin
          if (can_push) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // pause flags: written by create, start and stop only
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && q_ready_o) begin
      case (q_data_i.op)
        ptd_pkg::OP_CREATE: paused_q[cmd_idx] <= q_data_i.start_paused;
        ptd_pkg::OP_START:  if (occ_q[cmd_idx]) paused_q[cmd_idx] <= 1'b0;
        ptd_pkg::OP_STOP:   if (occ_q[cmd_idx]) paused_q[cmd_idx] <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cd_we) cd_mem[cd_wa] <= cd_wd;
    if (rd_en) cd_rd_q <= cd_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (per_we) per_mem[cmd_idx] <= q_data_i.period;
    if (rd_en)  per_rd_q <= per_mem[rd_addr];
  end

endmodule

// File: test/tb.sv
// Self-checking testbench for the periodic task tick dispatcher top level.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned TASK_SLOTS    = ptd_pkg::DEF_TASK_SLOTS;
  localparam int unsigned RELOAD_OFFSET = ptd_pkg::DEF_RELOAD_OFFSET;

  // func codes past FUNC_STOP are undefined and must come back as errors
  localparam logic [ptd_pkg::FUNC_W-1:0] FUNC_BAD_MIN = ptd_pkg::FUNC_STOP + 1'b1;
  localparam logic [ptd_pkg::FUNC_W-1:0] FUNC_BAD_MAX = '1;

  // status codes on a result
  localparam logic ST_OK  = 1'b0;
  localparam logic ST_ERR = 1'b1;

  localparam logic [ptd_pkg::TIME_W-1:0] T_MAX = '1;

  localparam int unsigned NUM_DIR     = 25;
  localparam int unsigned NUM_RAND    = 325;
  localparam int unsigned HOLD_CYCLES = 400;   // long receiver hold-off
  localparam int unsigned HOLD_AT     = 120;   // random item that triggers it
  // leave room for both a tick walk and a command result
  localparam int unsigned DRAIN_CYCLES = 2 * (TASK_SLOTS + 2) + 8;
  // worst case ~350 items x (8 results x slow receiver + sender gap + walk),
  // plus the hold-off and reset, taken many times over
  localparam int unsigned CYCLE_LIMIT = 300000;

  // one stimulus row: command fields plus an optional typed-in result
  typedef struct packed {
    logic [ptd_pkg::FUNC_W-1:0] func;
    logic [ptd_pkg::SLOT_W-1:0] task_slot;
    logic [ptd_pkg::TIME_W-1:0] period;
    logic [ptd_pkg::TIME_W-1:0] first_delay;
    logic                       start_paused;
    logic                       chk;   // 1: use st below instead of the predictor
    logic                       st;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  ptd_cmd_if cmd_if ();
  ptd_res_if res_if ();

  periodic_task_tick_dispatcher_top #(
    .TASK_SLOTS   (TASK_SLOTS),
    .RELOAD_OFFSET(RELOAD_OFFSET)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .res_o (res_if)
  );

  // ---------------------------------------------------------------------------
  // Directed table. Rows with chk = 1 carry a result that is obvious on sight
  // (reset state, range and empty-slot errors, plain command acks); the ticks
  // after slots get populated go to the predictor.
  // ---------------------------------------------------------------------------
  stim_row_t dir_tab [NUM_DIR] = '{
    // nothing populated yet: a tick gives a single empty result
    '{ptd_pkg::FUNC_TICK,   8'd0,   32'd0, 32'd0, 1'b0, 1'b1, ST_OK},
    // delete, start, stop on an empty slot
    '{ptd_pkg::FUNC_DELETE, 8'd0,   32'd0, 32'd0, 1'b0, 1'b1, ST_ERR},
    '{ptd_pkg::FUNC_START,  8'd3,   32'd0, 32'd0, 1'b0, 1'b1, ST_ERR},
    '{ptd_pkg::FUNC_STOP,   8'd7,   32'd0, 32'd0, 1'b1, 1'b1, ST_ERR},
    // create just past the table and at the top of the slot field
    '{ptd_pkg::FUNC_CREATE, 8'd8,   32'd5, 32'd2, 1'b0, 1'b1, ST_ERR},
    '{ptd_pkg::FUNC_CREATE, 8'd255, T_MAX, T_MAX, 1'b1, 1'b1, ST_ERR},
    // undefined func codes
    '{FUNC_BAD_MIN,        8'd0, 32'd1, 32'd0, 1'b0, 1'b1, ST_ERR},
    '{FUNC_BAD_MIN + 3'd1, 8'd1, 32'd1, 32'd0, 1'b0, 1'b1, ST_ERR},
    '{FUNC_BAD_MAX,        8'd2, 32'd1, 32'd0, 1'b0, 1'b1, ST_ERR},
    // slot 0 fires on every tick; slot 7 has a period below the offset
    '{ptd_pkg::FUNC_CREATE, 8'd0,   32'd1, 32'd0, 1'b0, 1'b1, ST_OK},
    '{ptd_pkg::FUNC_CREATE, 8'd7,   32'd0, 32'd0, 1'b0, 1'b1, ST_OK},
    // slot 3 parked with all-ones period and delay
    '{ptd_pkg::FUNC_CREATE, 8'd3,   T_MAX, T_MAX, 1'b1, 1'b1, ST_OK},
    '{ptd_pkg::FUNC_TICK,   8'd0,   32'd0, 32'd0, 1'b0, 1'b0, ST_OK},
    '{ptd_pkg::FUNC_TICK,   8'd5,   32'd0, 32'd0, 1'b0, 1'b0, ST_OK},
    '{ptd_pkg::FUNC_START,  8'd3,   32'd0, 32'd0, 1'b0, 1'b1, ST_OK},
    '{ptd_pkg::FUNC_STOP,   8'd3,   32'd0, 32'd0, 1'b0, 1'b1, ST_OK},
    // overwrite an occupied slot, then fill the rest: every slot fires
    '{ptd_pkg::FUNC_CREATE, 8'd3,   32'd1, 32'd0, 1'b0, 1'b1, ST_OK},
    '{ptd_pkg::FUNC_CREATE, 8'd1,   32'd1, 32'd0, 1'b0, 1'b1, ST_OK},
    '{ptd_pkg::FUNC_CREATE, 8'd2,   32'd1, 32'd0, 1'b0, 1'b1, ST_OK},
    '{ptd_pkg::FUNC_CREATE, 8'd4,   32'd1, 32'd0, 1'b0, 1'b1, ST_OK},
    '{ptd_pkg::FUNC_CREATE, 8'd5,   32'd1, 32'd0, 1'b0, 1'b1, ST_OK},
    '{ptd_pkg::FUNC_CREATE, 8'd6,   32'd1, 32'd0, 1'b0, 1'b1, ST_OK},
    '{ptd_pkg::FUNC_TICK,   8'd0,   32'd0, 32'd0, 1'b0, 1'b0, ST_OK},
    '{ptd_pkg::FUNC_DELETE, 8'd7,   32'd0, 32'd0, 1'b0, 1'b1, ST_OK},
    '{ptd_pkg::FUNC_DELETE, 8'd7,   32'd0, 32'd0, 1'b0, 1'b1, ST_ERR}
  };

  // ---------------------------------------------------------------------------
  // Predicted slot table
  // ---------------------------------------------------------------------------
  logic                       slot_busy   [TASK_SLOTS];
  logic                       slot_held   [TASK_SLOTS];
  logic [ptd_pkg::TIME_W-1:0] slot_left   [TASK_SLOTS];
  logic [ptd_pkg::TIME_W-1:0] slot_reload [TASK_SLOTS];

  ptd_pkg::res_t step_res[$];          // results of the command just accepted
  ptd_pkg::res_t dispatch_results[$];  // results still owed by the block
  stim_row_t     offered_rows[$];      // rows on the command channel, in order

  int unsigned err_cnt   = 0;
  int unsigned cycle_cnt = 0;
  bit          hold_req  = 1'b0;

  // Applies one accepted transaction to the slot table and leaves the
  // results it causes in step_res.
  function automatic void apply_command(logic [ptd_pkg::FUNC_W-1:0] f,
                                        logic [ptd_pkg::SLOT_W-1:0] s,
                                        logic [ptd_pkg::TIME_W-1:0] per,
                                        logic [ptd_pkg::TIME_W-1:0] dly,
                                        logic sp);
    int unsigned   i;
    int unsigned   idx;
    logic          in_rng;
    logic          err;
    ptd_pkg::res_t r;
    step_res.delete();
    in_rng = (s < TASK_SLOTS);
    idx    = in_rng ? int'(s) : 0;
    err    = ST_OK;
    if (f == ptd_pkg::FUNC_TICK) begin
      // walk in priority order; fire on zero and reload, else count down
      for (i = 0; i < TASK_SLOTS; i++) begin
        if (slot_busy[i] && !slot_held[i]) begin
          if (slot_left[i] == '0) begin
            slot_left[i] = (slot_reload[i] >= RELOAD_OFFSET) ?
                           slot_reload[i] - RELOAD_OFFSET : '0;
            if (step_res.size() < ptd_pkg::MAX_RESULTS) begin
              r = '{ST_OK, 1'b1, ptd_pkg::FSLOT_W'(i), 1'b0};
              step_res.push_back(r);
            end
          end else begin
            slot_left[i] = slot_left[i] - 1'b1;
          end
        end
      end
      if (step_res.size() == 0) begin
        r = '{ST_OK, 1'b0, '0, 1'b1};
        step_res.push_back(r);
      end else begin
        step_res[step_res.size()-1].last = 1'b1;
      end
    end else begin
      case (f)
        ptd_pkg::FUNC_CREATE: begin
          if (in_rng) begin
            slot_busy[idx]   = 1'b1;
            slot_held[idx]   = sp;
            slot_left[idx]   = dly;
            slot_reload[idx] = per;
          end else begin
            err = ST_ERR;
          end
        end
        ptd_pkg::FUNC_DELETE: begin
          if (in_rng && slot_busy[idx]) slot_busy[idx] = 1'b0;
          else err = ST_ERR;
        end
        ptd_pkg::FUNC_START: begin
          if (in_rng && slot_busy[idx]) slot_held[idx] = 1'b0;
          else err = ST_ERR;
        end
        ptd_pkg::FUNC_STOP: begin
          if (in_rng && slot_busy[idx]) slot_held[idx] = 1'b1;
          else err = ST_ERR;
        end
        default: err = ST_ERR;
      endcase
      r = '{err, 1'b0, '0, 1'b1};
      step_res.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[periodic_task_tick_dispatcher_top] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted command transaction, check every
  // accepted result transaction against the oldest prediction. Both are read
  // at the rising edge, before the block's registers update.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    stim_row_t     row;
    ptd_pkg::res_t got;
    ptd_pkg::res_t want;
    if (rst_ni) begin
      if (cmd_if.valid && cmd_if.ready) begin
        row = offered_rows.pop_front();
        // always run the predictor so the slot table stays in step
        apply_command(cmd_if.func, cmd_if.task_slot, cmd_if.period,
                      cmd_if.first_delay, cmd_if.start_paused);
        if (row.chk) begin
          want = '{row.st, 1'b0, '0, 1'b1};
          dispatch_results.push_back(want);
        end else begin
          foreach (step_res[k]) dispatch_results.push_back(step_res[k]);
        end
      end
      if (res_if.valid && res_if.ready) begin
        got = '{res_if.status, res_if.fired, res_if.fired_slot, res_if.last};
        if (dispatch_results.size() == 0) begin
          $display("%0t: unexpected result: status=%0b fired=%0b slot=%0d last=%0b",
                   $time, got.status, got.fired, got.fired_slot, got.last);
          err_cnt++;
        end else begin
          want = dispatch_results.pop_front();
          if (got.status !== want.status || got.fired !== want.fired ||
              got.fired_slot !== want.fired_slot || got.last !== want.last) begin
            $display({"%0t: result mismatch: expected status=%0b fired=%0b slot=%0d",
                      " last=%0b, got status=%0b fired=%0b slot=%0d last=%0b"},
                     $time, want.status, want.fired, want.fired_slot, want.last,
                     got.status, got.fired, got.fired_slot, got.last);
            err_cnt++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: ready follows its own pattern in spans of random length
  // (always ready, mostly ready, mostly stalled, or a regular pattern). When the
  // command side raises hold_req, ready stays low for HOLD_CYCLES so the
  // output register and the command queue fill and cmd ready drops.
  // ---------------------------------------------------------------------------
  initial begin : res_stall_gen
    int unsigned mode;
    int unsigned span;
    int unsigned k;
    int unsigned hold_cnt;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        @(negedge clk_i);
        res_if.ready = 1'b0;
        for (hold_cnt = 1; hold_cnt < HOLD_CYCLES; hold_cnt++) @(negedge clk_i);
        hold_req = 1'b0;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 64);
      for (k = 0; k < span; k++) begin
        @(negedge clk_i);
        case (mode)
          0:       res_if.ready = 1'b1;
          1:       res_if.ready = ($urandom_range(0, 3) != 0);
          2:       res_if.ready = ($urandom_range(0, 3) == 0);
          default: res_if.ready = (k % 3 == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Command side: directed table first, then random traffic in bursts.
  // Inputs change only at the falling edge.
  // ---------------------------------------------------------------------------

  // Offers one row and returns at the edge where the transaction is taken.
  task automatic offer_cmd(stim_row_t row);
    @(negedge clk_i);
    cmd_if.valid        = 1'b1;
    cmd_if.func         = row.func;
    cmd_if.task_slot    = row.task_slot;
    cmd_if.period       = row.period;
    cmd_if.first_delay  = row.first_delay;
    cmd_if.start_paused = row.start_paused;
    offered_rows.push_back(row);
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
  endtask

  // Drops valid when n is nonzero; the idle payload is junk the block must ignore.
  task automatic idle_cmds(int unsigned n);
    if (n != 0) begin
      @(negedge clk_i);
      cmd_if.valid        = 1'b0;
      cmd_if.func         = ptd_pkg::FUNC_W'($urandom);
      cmd_if.task_slot    = ptd_pkg::SLOT_W'($urandom);
      cmd_if.period       = $urandom;
      cmd_if.first_delay  = $urandom;
      cmd_if.start_paused = 1'($urandom);
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  initial begin : stimulus
    stim_row_t   row;
    int unsigned n;
    int unsigned pick;
    int unsigned burst_left;

    cmd_if.valid        = 1'b0;
    cmd_if.func         = ptd_pkg::FUNC_TICK;
    cmd_if.task_slot    = '0;
    cmd_if.period       = '0;
    cmd_if.first_delay  = '0;
    cmd_if.start_paused = 1'b0;
    foreach (slot_busy[i]) begin
      slot_busy[i]   = 1'b0;
      slot_held[i]   = 1'b0;
      slot_left[i]   = '0;
      slot_reload[i] = '0;
    end

    @(posedge rst_ni);

    for (n = 0; n < NUM_DIR; n++) begin
      offer_cmd(dir_tab[n]);
      idle_cmds($urandom_range(0, 3));
    end

    // Random part: mostly legal traffic on real slots with short periods and
    // delays so that slots actually fire; a tenth of the slot numbers and a
    // few func codes are out of range, and some times are full 32-bit values.
    burst_left = 0;
    for (n = 0; n < NUM_RAND; n++) begin
      if (burst_left == 0) begin
        idle_cmds(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
        burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      if (n == HOLD_AT) hold_req = 1'b1;

      pick = $urandom_range(0, 99);
      if (pick < 34)      row.func = ptd_pkg::FUNC_TICK;
      else if (pick < 58) row.func = ptd_pkg::FUNC_CREATE;
      else if (pick < 68) row.func = ptd_pkg::FUNC_DELETE;
      else if (pick < 80) row.func = ptd_pkg::FUNC_START;
      else if (pick < 93) row.func = ptd_pkg::FUNC_STOP;
      else row.func = ptd_pkg::FUNC_W'($urandom_range(FUNC_BAD_MIN, FUNC_BAD_MAX));
      row.task_slot    = ($urandom_range(0, 9) == 0) ? ptd_pkg::SLOT_W'($urandom) :
                         ptd_pkg::SLOT_W'($urandom_range(0, TASK_SLOTS - 1));
      row.period       = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(1, 6);
      row.first_delay  = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 5);
      row.start_paused = ($urandom_range(0, 3) == 0);
      row.chk          = 1'b0;
      row.st           = ST_OK;
      offer_cmd(row);
    end

    @(negedge clk_i);
    cmd_if.valid = 1'b0;

    // wait for every owed result, then give stray results time to show up
    while (dispatch_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("[periodic_task_tick_dispatcher_top] OK");
    end else begin
      $display("[periodic_task_tick_dispatcher_top] ERROR");
    end
    $finish;
  end

endmodule
